// ----- hdl/gamf_pkg.sv -----
// Shared types, codes and helpers for the global alignment matrix fill block.
// No dependencies; used by the top level, row buffer, cell and testbench.
`timescale 1ns / 1ps

package gamf_pkg;

    localparam int VALUE_W   = 32;
    localparam int WIDE_W    = 34;
    localparam int SCORE_W   = 16;
    localparam int PEN_W     = 15;
    localparam int COUNT_W   = 11;
    localparam int RUN_W     = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] MOVE_DIAG = 2'd0;
    localparam logic [1:0] MOVE_LEFT = 2'd1;
    localparam logic [1:0] MOVE_UP   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_OPEN    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_EXTEND  = 2'd3;

    // One entry of the previous-row buffer
    typedef struct packed {
        logic [1:0]                move;
        logic signed [VALUE_W-1:0] value;
    } row_entry_t;

    // Everything the cell datapath needs besides stored state
    typedef struct packed {
        logic signed [SCORE_W-1:0] pair_score;
        logic [PEN_W-1:0]          open_penalty;
        logic [PEN_W-1:0]          extend_penalty;
        logic signed [VALUE_W-1:0] up_edge;
        logic signed [VALUE_W-1:0] left_edge;
        logic signed [VALUE_W-1:0] diag_edge;
        logic                      first_row;
        logic                      first_col;
        logic                      inner;
        logic                      last;
    } cell_req_t;

    // -(open + ext * run), saturated to 32 bits
    function automatic logic signed [VALUE_W-1:0] border_value(
        input logic [PEN_W-1:0] open,
        input logic [PEN_W-1:0] ext,
        input logic [RUN_W-1:0] run
    );
        logic [31:0] prod;
        logic [32:0] total;
        prod  = {17'b0, ext} * {15'b0, run};
        total = {1'b0, prod} + {18'b0, open};
        if (total > 33'h080000000) begin
            return 32'sh80000000;
        end
        return 32'(-total);
    endfunction

endpackage

// ----- hdl/global_alignment_matrix_fill_top.sv -----
// Top level of the global alignment matrix fill block.
// Depends on gamf_pkg, gamf_row_mem and gamf_cell.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready): one beat per matrix cell, row-major,
//   carrying the cell's pair_score and its column's open/extend penalties.
//   Output channel (out_valid/out_ready): one beat per cell with cell_value,
//   move (0 diagonal, 1 left, 2 above) and last_cell on the matrix's final
//   cell; after it the indices wrap and the next matrix starts at (1, 1).
//   Config channel (cfg_valid/cfg_ready): cfg_index 0 row_count,
//   1 column_count, 2 edge_open_penalty, 3 edge_extend_penalty. cfg_ready is
//   always high; write only while no cell is in flight.
//   Path: an accepted cell waits in the read stage, then enters the output register once that is free.
//   Throughput: one cell per cycle while the output is not stalled, set by the single
//   add-compare-select on the left neighbor and by the registered read port of the row
//   buffer, whose address comes from the column counter at accept time.
//   Reset: indices go to (1, 1), counts to 1, edge penalties to 0, the
//   pipeline empties. The row buffer is not cleared; row one never reads it.
//   Receiver stall: the output register holds its beat; one more cell can
//   sit in the read stage, after which in_ready drops until out_ready.
module global_alignment_matrix_fill_top #(
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_COLUMNS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    // cell input
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] pair_score,
    input  logic [14:0]        open_penalty,
    input  logic [14:0]        extend_penalty,
    // cell result
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] cell_value,
    output logic [1:0]         move,
    output logic               last_cell,
    // configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [14:0]        cfg_data
);

    localparam int RW  = $clog2(MAX_ROWS + 1);
    localparam int CW  = $clog2(MAX_COLUMNS + 1);
    localparam int AW  = $clog2(MAX_COLUMNS);
    localparam int RUN = gamf_pkg::RUN_W;

    // configuration registers
    logic [10:0] row_count_reg;
    logic [10:0] column_count_reg;
    logic [14:0] edge_open_reg;
    logic [14:0] edge_extend_reg;

    // position counters
    logic [RW-1:0] row_index_reg;
    logic [CW-1:0] column_index_reg;
    logic [RW-1:0] row_index_next;
    logic [CW-1:0] column_index_next;

    // read stage
    logic                s0_valid_reg;
    gamf_pkg::cell_req_t s0_req_reg;
    logic [AW-1:0]       s0_addr_reg;

    // running neighbor state
    logic signed [31:0] left_value_reg;
    logic [1:0]         left_move_reg;
    logic signed [31:0] diag_value_reg;

    // output register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [31:0] cell_value_reg;
    logic [1:0]         move_reg;
    logic               last_cell_reg;

    logic [RW-1:0]        rows_eff;
    logic [CW-1:0]        cols_eff;
    logic [RW-1:0]        i_cur;
    logic [CW-1:0]        j_cur;
    logic                 in_accept;
    logic                 advance;
    gamf_pkg::cell_req_t  req_new;
    gamf_pkg::row_entry_t prev_entry;
    gamf_pkg::row_entry_t wr_entry;
    logic signed [31:0]   cell_val;
    logic [1:0]           cell_move;
    logic signed [31:0]   cell_up;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= 11'd1;
            column_count_reg <= 11'd1;
            edge_open_reg    <= '0;
            edge_extend_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                gamf_pkg::CFG_ROW_COUNT:    row_count_reg    <= cfg_data[10:0];
                gamf_pkg::CFG_COLUMN_COUNT: column_count_reg <= cfg_data[10:0];
                gamf_pkg::CFG_EDGE_OPEN:    edge_open_reg    <= cfg_data;
                gamf_pkg::CFG_EDGE_EXTEND:  edge_extend_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective counts: zero acts as one, large values clip to the maximum
    always_comb
    begin
        if (row_count_reg == '0)
        begin
            rows_eff = RW'(1);
        end
        else if (32'(row_count_reg) > 32'(MAX_ROWS))
        begin
            rows_eff = RW'(MAX_ROWS);
        end
        else
        begin
            rows_eff = RW'(row_count_reg);
        end

        if (column_count_reg == '0)
        begin
            cols_eff = CW'(1);
        end
        else if (32'(column_count_reg) > 32'(MAX_COLUMNS))
        begin
            cols_eff = CW'(MAX_COLUMNS);
        end
        else
        begin
            cols_eff = CW'(column_count_reg);
        end
    end

    // an index past a lowered count is treated as the end of row/matrix
    assign i_cur = ((row_index_reg == '0) || (row_index_reg > rows_eff))
                 ? rows_eff : row_index_reg;
    assign j_cur = ((column_index_reg == '0) || (column_index_reg > cols_eff))
                 ? cols_eff : column_index_reg;

    assign advance   = s0_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s0_valid_reg || advance;
    assign in_accept = in_valid && in_ready;

    // request for the read stage; edge products are formed here
    always_comb
    begin
        req_new.pair_score     = pair_score;
        req_new.open_penalty   = open_penalty;
        req_new.extend_penalty = extend_penalty;
        req_new.up_edge        = gamf_pkg::border_value(open_penalty, extend_penalty,
                                                        RUN'(j_cur) - RUN'(1));
        req_new.left_edge      = gamf_pkg::border_value(edge_open_reg, edge_extend_reg,
                                                        RUN'(i_cur) - RUN'(1));
        req_new.diag_edge      = gamf_pkg::border_value(edge_open_reg, edge_extend_reg,
                                                        RUN'(i_cur) - RUN'(2));
        req_new.first_row      = (i_cur == RW'(1));
        req_new.first_col      = (j_cur == CW'(1));
        req_new.inner          = (i_cur != RW'(1)) && (j_cur != CW'(1));
        req_new.last           = (i_cur == rows_eff) && (j_cur == cols_eff);
    end

    always_comb
    begin
        if (j_cur == cols_eff)
        begin
            column_index_next = CW'(1);
            row_index_next    = (i_cur == rows_eff) ? RW'(1) : i_cur + RW'(1);
        end
        else
        begin
            column_index_next = j_cur + CW'(1);
            row_index_next    = i_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_index_reg    <= RW'(1);
            column_index_reg <= CW'(1);
            s0_valid_reg     <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                row_index_reg    <= row_index_next;
                column_index_reg <= column_index_next;
                s0_valid_reg     <= 1'b1;
            end
            else if (advance)
            begin
                s0_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s0_req_reg  <= req_new;
            s0_addr_reg <= AW'(j_cur - CW'(1));
        end
    end

    // row buffer: read at accept, written back when the cell retires
    assign wr_entry.move  = cell_move;
    assign wr_entry.value = cell_val;

    gamf_row_mem #(
        .DEPTH (MAX_COLUMNS),
        .AW    (AW)
    ) u_row_mem (
        .clk   (clk),
        .we    (advance),
        .waddr (s0_addr_reg),
        .wdata (wr_entry),
        .re    (in_accept),
        .raddr (AW'(j_cur - CW'(1))),
        .rdata (prev_entry)
    );

    gamf_cell u_cell (
        .req        (s0_req_reg),
        .prev       (prev_entry),
        .left_value (left_value_reg),
        .left_move  (left_move_reg),
        .diag_value (diag_value_reg),
        .value      (cell_val),
        .move       (cell_move),
        .up_value   (cell_up)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_value_reg <= '0;
            left_move_reg  <= gamf_pkg::MOVE_DIAG;
            diag_value_reg <= '0;
        end
        else if (advance)
        begin
            left_value_reg <= cell_val;
            left_move_reg  <= cell_move;
            diag_value_reg <= cell_up;
        end
    end

    // output register
    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cell_value_reg <= cell_val;
            move_reg       <= cell_move;
            last_cell_reg  <= s0_req_reg.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_value = cell_value_reg;
    assign move       = move_reg;
    assign last_cell  = last_cell_reg;

endmodule

// ----- hdl/gamf_row_mem.sv -----
// Previous-row buffer: one write port, one registered read port.
// Depends on gamf_pkg for the entry type.
`timescale 1ns / 1ps

module gamf_row_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  gamf_pkg::row_entry_t  wdata,
    input  logic                  re,
    input  logic [AW-1:0]         raddr,
    output gamf_pkg::row_entry_t  rdata
);

    gamf_pkg::row_entry_t entries_reg [DEPTH];
    gamf_pkg::row_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            entries_reg[waddr] <= wdata;
        end
    end

    // write-first bypass: a read of the entry being written returns new data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= entries_reg[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/gamf_cell.sv -----
// Add-compare-select for one matrix cell.
// Depends on gamf_pkg for request/entry types and move codes.
`timescale 1ns / 1ps

module gamf_cell (
    input  gamf_pkg::cell_req_t  req,
    input  gamf_pkg::row_entry_t prev,
    input  logic signed [31:0]   left_value,
    input  logic [1:0]           left_move,
    input  logic signed [31:0]   diag_value,
    output logic signed [31:0]   value,
    output logic [1:0]           move,
    output logic signed [31:0]   up_value
);

    localparam logic signed [33:0] SAT_MAX = 34'sh0_7FFF_FFFF;
    localparam logic signed [33:0] SAT_MIN = -34'sh0_8000_0000;

    logic signed [31:0] up;
    logic signed [31:0] diag;
    logic signed [31:0] left;
    logic [14:0]        up_pen;
    logic [14:0]        left_pen;
    logic signed [33:0] from_diag;
    logic signed [33:0] from_left;
    logic signed [33:0] from_up;
    logic signed [33:0] best;

    assign up   = req.first_row ? req.up_edge : prev.value;
    assign diag = req.first_col ? (req.first_row ? 32'sd0 : req.diag_edge) : diag_value;
    assign left = req.first_col ? req.left_edge : left_value;

    // gap continuing the neighbor's own direction pays extension
    assign up_pen   = (req.inner && (prev.move == gamf_pkg::MOVE_UP))
                    ? req.extend_penalty : req.open_penalty;
    assign left_pen = (req.inner && (left_move == gamf_pkg::MOVE_LEFT))
                    ? req.extend_penalty : req.open_penalty;

    assign from_diag = 34'(diag) + 34'(req.pair_score);
    assign from_left = 34'(left) - $signed({19'b0, left_pen});
    assign from_up   = 34'(up) - $signed({19'b0, up_pen});

    // ties: diagonal, then left, then above
    always_comb
    begin
        best = from_diag;
        move = gamf_pkg::MOVE_DIAG;
        if (from_left > best)
        begin
            best = from_left;
            move = gamf_pkg::MOVE_LEFT;
        end
        if (from_up > best)
        begin
            best = from_up;
            move = gamf_pkg::MOVE_UP;
        end
    end

    always_comb
    begin
        if (best > SAT_MAX)
        begin
            value = 32'sh7FFFFFFF;
        end
        else if (best < SAT_MIN)
        begin
            value = 32'sh80000000;
        end
        else
        begin
            value = 32'(best);
        end
    end

    assign up_value = up;

endmodule

// ----- hdl/gamf_checker.sv -----
// Port-level checks for global_alignment_matrix_fill_top, attached by bind.
// Depends only on the top level's port names.
`timescale 1ns / 1ps

module gamf_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] cell_value,
    input logic [1:0]         move,
    input logic               last_cell,
    input logic               cfg_ready
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cell_value)
            && $stable(move) && $stable(last_cell))
        else $error("result beat changed while stalled");

    // input backpressure only comes from a full output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("in_ready low without output stall");

    // a result appears on an empty output only after its input beat has passed the read stage
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without matching input beat");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind global_alignment_matrix_fill_top gamf_checker u_gamf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cell_value (cell_value),
    .move       (move),
    .last_cell  (last_cell),
    .cfg_ready  (cfg_ready)
);

// ----- test/global_alignment_matrix_fill_top_tb.sv -----
// Self-checking testbench for global_alignment_matrix_fill_top: drives cell beats and
// register writes, predicts every cell score and move, and checks each output beat.
// Depends on gamf_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module global_alignment_matrix_fill_top_tb;

    localparam int MAX_ROWS       = 1024;
    localparam int MAX_COLUMNS    = 1024;
    localparam int IDLE_PCT       = 13;
    localparam int SETTLE_CYCLES  = 4;     // margin after draining, before a register write
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;  // well above the longest hold-off, HOLD_OFF
    localparam int HOLD_OFF       = 150;
    localparam int RANDOM_CELLS   = 800;

    localparam longint VALUE_MAX = 64'sd2147483647;
    localparam longint VALUE_MIN = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] value;
        logic [1:0]         move_dir;
        logic               last;
    } cell_result_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] pair_score;
    logic [14:0]        open_penalty;
    logic [14:0]        extend_penalty;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] cell_value;
    logic [1:0]         move;
    logic               last_cell;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [14:0]        cfg_data;

    // Predicted cell beats, oldest first
    cell_result_t due_cells[$];

    // Mirror of the block: registers, previous row, left/diagonal neighbors, indices
    logic [10:0]        cfg_rows;
    logic [10:0]        cfg_cols;
    logic [14:0]        cfg_edge_open;
    logic [14:0]        cfg_edge_ext;
    logic signed [31:0] row_values [MAX_COLUMNS];
    logic [1:0]         row_moves [MAX_COLUMNS];
    logic signed [31:0] left_value;
    logic [1:0]         left_move;
    logic signed [31:0] diag_value;
    logic [10:0]        row_idx;
    logic [10:0]        col_idx;

    int          idle_pct = IDLE_PCT;
    int unsigned stall_left = 0;
    int          quiet_cycles = 0;
    int          mismatch_count = 0;
    int          cells_sent = 0;
    int          cells_checked = 0;
    int          matrices_seen = 0;
    int          reg_writes = 0;

    global_alignment_matrix_fill_top #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pair_score     (pair_score),
        .open_penalty   (open_penalty),
        .extend_penalty (extend_penalty),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cell_value     (cell_value),
        .move           (move),
        .last_cell      (last_cell),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Score predictor
    // ------------------------------------------------------------------

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > VALUE_MAX)
        begin
            return 32'sh7FFFFFFF;
        end
        if (v < VALUE_MIN)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Border cell k of a gap run: -(open + ext * (k - 1))
    function automatic logic signed [31:0] gap_cost(input logic [14:0] op,
                                                    input logic [14:0] ext,
                                                    input logic [10:0] k);
        longint run;
        run = longint'(ext) * (longint'(k) - 64'sd1);
        return clamp32(-(longint'(op) + run));
    endfunction

    // Count 0 behaves as 1, anything above the maximum as the maximum
    function automatic logic [10:0] eff_count(input logic [10:0] c, input int maxv);
        if (c == 11'd0)
        begin
            return 11'd1;
        end
        if (int'(c) > maxv)
        begin
            return 11'(maxv);
        end
        return c;
    endfunction

    task automatic reset_mirror();
        cfg_rows      = 11'd1;
        cfg_cols      = 11'd1;
        cfg_edge_open = '0;
        cfg_edge_ext  = '0;
        foreach (row_values[c])
        begin
            row_values[c] = '0;
            row_moves[c]  = gamf_pkg::MOVE_DIAG;
        end
        left_value = '0;
        left_move  = gamf_pkg::MOVE_DIAG;
        diag_value = '0;
        row_idx    = 11'd1;
        col_idx    = 11'd1;
    endtask

    // Works out the cell at the current indices and queues its beat
    task automatic score_cell(input logic signed [15:0] score,
                              input logic [14:0] op,
                              input logic [14:0] ext);
        logic [10:0]        rows;
        logic [10:0]        cols;
        logic [10:0]        i;
        logic [10:0]        j;
        logic [9:0]         col;
        logic               inner;
        logic signed [31:0] up_v;
        logic signed [31:0] diag_v;
        logic signed [31:0] left_v;
        logic [14:0]        up_pen;
        logic [14:0]        left_pen;
        longint             via_diag;
        longint             via_left;
        longint             via_up;
        longint             best;
        logic [1:0]         mv;
        cell_result_t       res;

        rows = eff_count(cfg_rows, MAX_ROWS);
        cols = eff_count(cfg_cols, MAX_COLUMNS);
        i = row_idx;
        j = col_idx;
        // indices past a count lowered mid-matrix mean end of row / last row
        if (j < 11'd1 || j > cols)
        begin
            j = cols;
        end
        if (i < 11'd1 || i > rows)
        begin
            i = rows;
        end
        inner = (i != 11'd1) && (j != 11'd1);
        col   = 10'(j - 11'd1);

        up_v = (i == 11'd1) ? gap_cost(op, ext, j) : row_values[col];
        if (j == 11'd1)
        begin
            diag_v = (i == 11'd1) ? 32'sd0 : gap_cost(cfg_edge_open, cfg_edge_ext, i - 11'd1);
            left_v = gap_cost(cfg_edge_open, cfg_edge_ext, i);
        end
        else
        begin
            diag_v = diag_value;
            left_v = left_value;
        end

        // continuing the neighbor's own gap pays extension, otherwise open
        up_pen   = (inner && row_moves[col] == gamf_pkg::MOVE_UP) ? ext : op;
        left_pen = (inner && left_move == gamf_pkg::MOVE_LEFT) ? ext : op;

        via_diag = longint'(diag_v) + longint'(score);
        via_left = longint'(left_v) - longint'(left_pen);
        via_up   = longint'(up_v) - longint'(up_pen);

        // ties: diagonal, then left, then above; saturate after the choice
        best = via_diag;
        mv   = gamf_pkg::MOVE_DIAG;
        if (via_left > best)
        begin
            best = via_left;
            mv   = gamf_pkg::MOVE_LEFT;
        end
        if (via_up > best)
        begin
            best = via_up;
            mv   = gamf_pkg::MOVE_UP;
        end

        res.value    = clamp32(best);
        res.move_dir = mv;
        res.last     = (i >= rows) && (j >= cols);
        due_cells.push_back(res);

        row_values[col] = res.value;
        row_moves[col]  = mv;
        left_value = res.value;
        left_move  = mv;
        diag_value = up_v;

        if (j >= cols)
        begin
            col_idx = 11'd1;
            row_idx = (i >= rows) ? 11'd1 : i + 11'd1;
        end
        else
        begin
            col_idx = j + 11'd1;
            row_idx = i;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic signed [15:0] pick_score();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 8)) - 16'sd4;  // near zero, breeds ties
            1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [14:0] pick_penalty();
        case ($urandom_range(0, 3))
            0: return 15'($urandom_range(0, 3));
            1: return $urandom_range(0, 1) ? 15'h7FFF : 15'h0000;
            default: return 15'($urandom);
        endcase
    endfunction

    // Sends one cell beat; returns right after the edge that accepted it
    task automatic send_cell(input logic signed [15:0] score,
                             input logic [14:0] op,
                             input logic [14:0] ext);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        pair_score     = score;
        open_penalty   = op;
        extend_penalty = ext;
        in_valid       = 1'b1;
        do @(posedge clk); while (!in_ready);
        score_cell(score, op, ext);
        cells_sent++;
    endtask

    task automatic send_random_cell();
        send_cell(pick_score(), pick_penalty(), pick_penalty());
    endtask

    // Sends cells until the indices wrap back to the first cell
    task automatic fill_matrix();
        do send_random_cell(); while (!(row_idx == 11'd1 && col_idx == 11'd1));
    endtask

    // Stops offering cells and waits until every predicted beat has come back
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (due_cells.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Register write, only with the block idle
    task automatic write_reg(input logic [1:0] idx, input logic [14:0] data);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            gamf_pkg::CFG_ROW_COUNT:    cfg_rows      = data[10:0];
            gamf_pkg::CFG_COLUMN_COUNT: cfg_cols      = data[10:0];
            gamf_pkg::CFG_EDGE_OPEN:    cfg_edge_open = data;
            gamf_pkg::CFG_EDGE_EXTEND:  cfg_edge_ext  = data;
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_shape(input logic [14:0] rows, input logic [14:0] cols,
                             input logic [14:0] e_open, input logic [14:0] e_ext);
        write_reg(gamf_pkg::CFG_ROW_COUNT, rows);
        write_reg(gamf_pkg::CFG_COLUMN_COUNT, cols);
        write_reg(gamf_pkg::CFG_EDGE_OPEN, e_open);
        write_reg(gamf_pkg::CFG_EDGE_EXTEND, e_ext);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset shape is 1x1: every cell is a whole matrix with last_cell set
    task automatic test_reset_defaults();
        send_cell(16'sh0000, 15'h0000, 15'h0000);
        send_cell(16'sh7FFF, 15'h0000, 15'h0000);
        send_cell(16'sh8000, 15'h7FFF, 15'h7FFF);
    endtask

    // All-zero matrix for three-way ties, then field extremes with maximal edges
    task automatic test_directed_cells();
        logic signed [15:0] scores [8] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF,
                                           16'sh8000, 16'sh7FFF, 16'sh0001, 16'sh8000};
        logic [14:0]        opens  [8] = '{15'h0000, 15'h7FFF, 15'h0000, 15'h7FFF,
                                           15'h0001, 15'h0000, 15'h7FFF, 15'h0000};
        logic [14:0]        exts   [8] = '{15'h7FFF, 15'h0000, 15'h0000, 15'h7FFF,
                                           15'h0000, 15'h0001, 15'h0000, 15'h7FFF};
        set_shape(15'd3, 15'd3, 15'd0, 15'd0);
        repeat (9) send_cell(16'sh0000, 15'h0000, 15'h0000);
        set_shape(15'd2, 15'd4, 15'h7FFF, 15'h7FFF);
        for (int k = 0; k < 8; k++)
        begin
            send_cell(scores[k], opens[k], exts[k]);
        end
    endtask

    // Zero counts act as one; oversized counts run until lowered mid-matrix
    task automatic test_count_limits();
        set_shape(15'd0, 15'd0, pick_penalty(), pick_penalty());
        fill_matrix();
        set_shape(15'd0, 15'd6, pick_penalty(), pick_penalty());
        fill_matrix();
        set_shape(15'd5, 15'd0, pick_penalty(), pick_penalty());
        fill_matrix();
        set_shape(15'd2047, 15'd3, 15'h7FFF, 15'h7FFF);
        repeat (12) send_random_cell();        // now at row 5, column 1
        write_reg(gamf_pkg::CFG_ROW_COUNT, 15'd5);
        fill_matrix();
        set_shape(15'd3, 15'd2047, pick_penalty(), pick_penalty());
        repeat (10) send_random_cell();        // now at row 1, column 11
        write_reg(gamf_pkg::CFG_COLUMN_COUNT, 15'd4);
        fill_matrix();
    endtask

    // Lowering a count mid-matrix ends the current row or makes it the last row
    task automatic test_mid_matrix_shrink();
        set_shape(15'd6, 15'd6, 15'd300, 15'd20);
        repeat (15) send_random_cell();        // now at row 3, column 4
        write_reg(gamf_pkg::CFG_COLUMN_COUNT, 15'd2);
        fill_matrix();
        set_shape(15'd6, 15'd5, 15'd0, 15'h7FFF);
        repeat (16) send_random_cell();        // now at row 4, column 2
        write_reg(gamf_pkg::CFG_ROW_COUNT, 15'd2);
        fill_matrix();
    endtask

    // Receiver holds off long enough for the block to stall its input,
    // then the sender pauses until everything has drained
    task automatic test_backpressure();
        set_shape(15'd4, 15'd8, 15'd64, 15'd8);
        idle_pct = 0;
        send_random_cell();
        stall_left = HOLD_OFF;
        repeat (31) send_random_cell();
        wait_drained();
        fill_matrix();
        idle_pct = IDLE_PCT;
    endtask

    // Random shapes and penalties, whole matrices plus occasional shrinks
    task automatic test_random_matrices();
        int          start;
        int          k;
        int unsigned rows;
        int unsigned cols;
        int unsigned cells;
        start = cells_sent;
        k = 0;
        while (cells_sent - start < RANDOM_CELLS)
        begin
            // a long stretch of matrices with neither side idling
            idle_pct = (k >= 8 && k < 30) ? 0 : IDLE_PCT;
            rows = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 6) : $urandom_range(1, 16);
            cols = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 10) : $urandom_range(1, 32);
            // upper data bits are outside the count fields
            set_shape({4'($urandom), 11'(rows)}, {4'($urandom), 11'(cols)},
                      pick_penalty(), pick_penalty());
            rows  = 32'(eff_count(cfg_rows, MAX_ROWS));
            cols  = 32'(eff_count(cfg_cols, MAX_COLUMNS));
            cells = rows * cols;
            if (cells >= 2 && $urandom_range(0, 7) == 0)
            begin
                repeat ($urandom_range(1, cells - 1)) send_random_cell();
                if ($urandom_range(0, 1) == 1)
                begin
                    write_reg(gamf_pkg::CFG_COLUMN_COUNT,
                              {4'($urandom), 11'($urandom_range(0, cols - 1))});
                end
                else
                begin
                    write_reg(gamf_pkg::CFG_ROW_COUNT,
                              {4'($urandom), 11'($urandom_range(0, rows - 1))});
                end
            end
            fill_matrix();
            k++;
        end
        idle_pct = IDLE_PCT;
    endtask

    // ------------------------------------------------------------------
    // Receiver, checker, watchdog
    // ------------------------------------------------------------------

    // out_ready changes at the falling edge; a hold-off is counted down here
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready = ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    task automatic flag_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t: cell %0d %s mismatch: expected %0d, got %0d",
                     $realtime, cells_checked, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_beats
        cell_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (due_cells.size() == 0)
            begin
                flag_mismatch("unexpected beat, value", 0, longint'(cell_value));
            end
            else
            begin
                want = due_cells.pop_front();
                if (cell_value !== want.value)
                begin
                    flag_mismatch("cell_value", longint'(want.value), longint'(cell_value));
                end
                if (move !== want.move_dir)
                begin
                    flag_mismatch("move", longint'(want.move_dir), longint'(move));
                end
                if (last_cell !== want.last)
                begin
                    flag_mismatch("last_cell", longint'(want.last), longint'(last_cell));
                end
                if (want.last)
                begin
                    matrices_seen++;
                end
            end
            cells_checked++;
        end
    end

    // Ends the run when no beat of any channel moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no beat for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, due_cells.size());
            $display("FAIL global_alignment_matrix_fill_top");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        pair_score     = '0;
        open_penalty   = '0;
        extend_penalty = '0;
        cfg_valid      = 1'b0;
        cfg_index      = gamf_pkg::CFG_ROW_COUNT;
        cfg_data       = '0;
        reset_mirror();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_directed_cells();
        test_count_limits();
        test_mid_matrix_shrink();
        test_backpressure();
        test_random_matrices();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d cells over %0d matrices with %0d register writes:",
                 cells_checked, matrices_seen, reg_writes);
        $display("  ties, field extremes, zero and oversized counts, mid-matrix shrink, stalls.");
        if (mismatch_count == 0 && due_cells.size() == 0)
        begin
            $display("PASS global_alignment_matrix_fill_top");
        end
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatch_count, due_cells.size());
            $display("FAIL global_alignment_matrix_fill_top");
        end
        $finish;
    end

endmodule
